// ----- rtl/core/rfp_pkg.sv -----
// Shared types and constants for the H.264 RTP FU-A packetizer.
// No dependencies; used by rfp_ctrl, rfp_emit and the top level.
package rfp_pkg;

	localparam int MAX_PAYLOAD_LIMIT = 4096;

	localparam int HDR_BYTES  = 12;
	localparam int FU_BYTES   = 2;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int IDX_W      = 4;
	localparam int LEN_W      = 13;

	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SOURCE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_SEQ     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 2'd3;

	localparam logic [6:0]  RST_PAYLOAD_TYPE = 7'd96;
	localparam logic [31:0] RST_SYNC_SOURCE  = 32'd0;
	localparam logic [15:0] RST_INIT_SEQ     = 16'd0;
	localparam logic [12:0] RST_MAX_PAYLOAD  = 13'd1400;

	localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
	localparam logic [7:0] NRI_MASK         = 8'hE0;
	localparam logic [7:0] FU_A_TYPE        = 8'd28;
	localparam logic [7:0] NAL_TYPE_MASK    = 8'h1F;
	localparam logic [7:0] FU_START_BIT     = 8'h80;
	localparam logic [7:0] FU_END_BIT       = 8'h40;

	// byte positions inside one word burst
	localparam logic [IDX_W-1:0] IDX_FIRST    = 4'd0;
	localparam logic [IDX_W-1:0] IDX_HDR_LAST = 4'd11;
	localparam logic [IDX_W-1:0] IDX_FU_IND   = 4'd12;
	localparam logic [IDX_W-1:0] IDX_FU_HDR   = 4'd13;
	localparam logic [IDX_W-1:0] IDX_BYTE     = 4'd14;

	typedef struct packed {
		logic [7:0]       data;
		logic [7:0]       fu_ind;
		logic [7:0]       fu_hdr;
		logic             marker;
		logic [6:0]       pt;
		logic [15:0]      seq;
		logic [31:0]      ts;
		logic [31:0]      ssrc;
		logic [LEN_W-1:0] total;
		logic             last;
		logic             frag;
		logic [IDX_W-1:0] start;
	} plan_t;

endpackage

// ----- rtl/core/rfp_ctrl.sv -----
// Configuration registers, NAL/packet tracking state and per-word decode.
// Depends on rfp_pkg; produces an rfp_pkg::plan_t for rfp_emit.
module rfp_ctrl #(
	parameter int MAX_PAYLOAD_LIMIT = rfp_pkg::MAX_PAYLOAD_LIMIT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfp_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           accept,
	input  logic [7:0]                     nal_byte,
	input  logic [23:0]                    nal_length,
	input  logic [31:0]                    media_time,
	input  logic                           frame_end,
	output rfp_pkg::plan_t                 plan,
	output logic                           has_out
);

	localparam int PW = $clog2(MAX_PAYLOAD_LIMIT + 1);

	logic [6:0]                    payload_type_q;
	logic [31:0]                   sync_source_q;
	logic [12:0]                   max_payload_q;
	logic [15:0]                   seq_q;
	logic [23:0]                   nal_left_q;
	logic [PW-1:0]                 pkt_left_q;
	logic                          first_frag_q;
	logic [7:0]                    nal_hdr_q;
	logic [rfp_pkg::LEN_W-1:0]     total_q;

	logic [23:0]                   mp, m, m2, len1, cnt, nal_n;
	logic [PW-1:0]                 pkt_n;
	logic                          first_n, seq_inc, frag_last;
	logic [7:0]                    hdr_n;

	always_comb begin
		mp = 24'(max_payload_q);
		if (mp < 24'd3) begin
			m = 24'd3;
		end else if (mp > 24'(MAX_PAYLOAD_LIMIT)) begin
			m = 24'(MAX_PAYLOAD_LIMIT);
		end else begin
			m = mp;
		end
		m2 = m - 24'(rfp_pkg::FU_BYTES);
		len1 = (nal_length == 24'd0) ? 24'd1 : nal_length;
		cnt = (m2 > nal_left_q) ? nal_left_q : m2;
		frag_last = (cnt == nal_left_q);

		plan.data   = nal_byte;
		plan.fu_ind = (nal_hdr_q & rfp_pkg::NRI_MASK) | rfp_pkg::FU_A_TYPE;
		plan.fu_hdr = (nal_hdr_q & rfp_pkg::NAL_TYPE_MASK)
			| (first_frag_q ? rfp_pkg::FU_START_BIT : 8'h00)
			| (frag_last ? rfp_pkg::FU_END_BIT : 8'h00);
		plan.marker = 1'b0;
		plan.pt     = payload_type_q;
		plan.seq    = seq_q;
		plan.ts     = media_time;
		plan.ssrc   = sync_source_q;
		plan.total  = total_q;
		plan.frag   = 1'b0;
		plan.start  = rfp_pkg::IDX_BYTE;

		has_out = 1'b1;
		seq_inc = 1'b0;
		first_n = first_frag_q;
		hdr_n   = nal_hdr_q;
		nal_n   = nal_left_q - 24'd1;
		pkt_n   = pkt_left_q - PW'(1);

		if (nal_left_q == 24'd0) begin
			nal_n = len1 - 24'd1;
			if (len1 <= m) begin
				first_n      = 1'b0;
				seq_inc      = 1'b1;
				pkt_n        = PW'(len1 - 24'd1);
				plan.total   = rfp_pkg::LEN_W'(len1 + 24'(rfp_pkg::HDR_BYTES));
				plan.marker  = frame_end;
				plan.start   = rfp_pkg::IDX_FIRST;
			end else begin
				has_out = 1'b0;
				first_n = 1'b1;
				hdr_n   = nal_byte;
				pkt_n   = '0;
			end
		end else if (pkt_left_q == '0) begin
			first_n     = 1'b0;
			seq_inc     = 1'b1;
			pkt_n       = PW'(cnt - 24'd1);
			plan.total  = rfp_pkg::LEN_W'(cnt + 24'(rfp_pkg::HDR_BYTES + rfp_pkg::FU_BYTES));
			plan.marker = frag_last & frame_end;
			plan.frag   = 1'b1;
			plan.start  = rfp_pkg::IDX_FIRST;
		end
		plan.last = (pkt_n == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_type_q <= rfp_pkg::RST_PAYLOAD_TYPE;
			sync_source_q  <= rfp_pkg::RST_SYNC_SOURCE;
			max_payload_q  <= rfp_pkg::RST_MAX_PAYLOAD;
			seq_q          <= rfp_pkg::RST_INIT_SEQ;
			nal_left_q     <= '0;
			pkt_left_q     <= '0;
			first_frag_q   <= 1'b0;
			nal_hdr_q      <= '0;
			total_q        <= '0;
		end else begin
			if (accept) begin
				nal_left_q   <= nal_n;
				pkt_left_q   <= pkt_n;
				first_frag_q <= first_n;
				nal_hdr_q    <= hdr_n;
				total_q      <= plan.total;
				if (seq_inc) begin
					seq_q <= seq_q + 16'd1;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					rfp_pkg::REG_PAYLOAD_TYPE: payload_type_q <= cfg_data[6:0];
					rfp_pkg::REG_SYNC_SOURCE:  sync_source_q  <= cfg_data;
					rfp_pkg::REG_INIT_SEQ:     seq_q          <= cfg_data[15:0];
					rfp_pkg::REG_MAX_PAYLOAD:  max_payload_q  <= cfg_data[12:0];
					default: ;
				endcase
			end
		end
	end

	a_first_frag_open: assert property (@(posedge clk) disable iff (!arst_n)
		first_frag_q |-> nal_left_q != 24'd0)
		else $error("first fragment pending with no NAL bytes left");

	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && seq_inc && !cfg_we |=> seq_q == $past(seq_q) + 16'd1)
		else $error("sequence number did not advance on packet open");

endmodule

// ----- rtl/core/rfp_emit.sv -----
// Word register and byte serializer: plays one plan as 1, 13 or 15 bytes.
// Depends on rfp_pkg; fed by rfp_ctrl, drives the output register.
module rfp_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  rfp_pkg::plan_t              plan,
	output logic                        free,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  packet_byte,
	output logic                        packet_end,
	output logic [rfp_pkg::LEN_W-1:0]   packet_length
);

	logic                        valid_s1;
	rfp_pkg::plan_t              plan_s1;
	logic [rfp_pkg::IDX_W-1:0]   idx_s1;
	logic                        out_valid_q;
	logic [7:0]                  byte_q;
	logic                        end_q;
	logic [rfp_pkg::LEN_W-1:0]   len_q;

	logic                        load_out, adv, done;
	logic [rfp_pkg::IDX_W-1:0]   idx_n;
	logic [7:0]                  byte_n;

	assign load_out = !out_valid_q || out_ready;
	assign adv      = valid_s1 && load_out;
	assign done     = adv && (idx_s1 == rfp_pkg::IDX_BYTE);
	assign free     = !valid_s1 || done;

	always_comb begin
		if (idx_s1 == rfp_pkg::IDX_HDR_LAST && !plan_s1.frag) begin
			idx_n = rfp_pkg::IDX_BYTE;
		end else begin
			idx_n = idx_s1 + 4'd1;
		end
		case (idx_s1)
			4'd0:  byte_n = rfp_pkg::RTP_VERSION_BYTE;
			4'd1:  byte_n = {plan_s1.marker, plan_s1.pt};
			4'd2:  byte_n = plan_s1.seq[15:8];
			4'd3:  byte_n = plan_s1.seq[7:0];
			4'd4:  byte_n = plan_s1.ts[31:24];
			4'd5:  byte_n = plan_s1.ts[23:16];
			4'd6:  byte_n = plan_s1.ts[15:8];
			4'd7:  byte_n = plan_s1.ts[7:0];
			4'd8:  byte_n = plan_s1.ssrc[31:24];
			4'd9:  byte_n = plan_s1.ssrc[23:16];
			4'd10: byte_n = plan_s1.ssrc[15:8];
			4'd11: byte_n = plan_s1.ssrc[7:0];
			4'd12: byte_n = plan_s1.fu_ind;
			4'd13: byte_n = plan_s1.fu_hdr;
			default: byte_n = plan_s1.data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			idx_s1      <= rfp_pkg::IDX_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
				idx_s1   <= plan.start;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end else if (adv) begin
				idx_s1 <= idx_n;
			end
			if (load_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			plan_s1 <= plan;
		end
		if (adv) begin
			byte_q <= byte_n;
			end_q  <= (idx_s1 == rfp_pkg::IDX_BYTE) && plan_s1.last;
			len_q  <= plan_s1.total;
		end
	end

	assign out_valid     = out_valid_q;
	assign packet_byte   = byte_q;
	assign packet_end    = end_q;
	assign packet_length = len_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_s1 <= rfp_pkg::IDX_BYTE)
		else $error("serializer index past payload byte");

	a_single_skip: assert property (@(posedge clk) disable iff (!arst_n)
		adv && idx_s1 == rfp_pkg::IDX_HDR_LAST && !plan_s1.frag
		|=> valid_s1 && idx_s1 == rfp_pkg::IDX_BYTE)
		else $error("single-NAL packet did not skip FU bytes");

endmodule

// ----- rtl/core/h264_rtp_fua_packetizer_unit.sv -----
// Top level: H.264 RTP packetizer with FU-A fragmentation.
// The first packet byte of an accepted NAL word passes the word register and then the output register.
// Throughput: one NAL byte per cycle inside a packet unless out_ready stalls;
// an opening word holds input until 13 (single NAL) or 15 (FU-A) bytes are played.
// Reset (arst_n, async low): registers to defaults, sequence 0, no NAL in flight.
module h264_rtp_fua_packetizer_unit #(
	parameter int MAX_PAYLOAD_LIMIT = rfp_pkg::MAX_PAYLOAD_LIMIT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfp_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     nal_byte,
	input  logic [23:0]                    nal_length,
	input  logic [31:0]                    media_time,
	input  logic                           frame_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     packet_byte,
	output logic                           packet_end,
	output logic [rfp_pkg::LEN_W-1:0]      packet_length
);

	rfp_pkg::plan_t plan;
	logic           has_out, accept, free;

	assign in_ready = free;
	assign accept   = in_valid && free;

	rfp_ctrl #(
		.MAX_PAYLOAD_LIMIT(MAX_PAYLOAD_LIMIT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.nal_byte   (nal_byte),
		.nal_length (nal_length),
		.media_time (media_time),
		.frame_end  (frame_end),
		.plan       (plan),
		.has_out    (has_out)
	);

	rfp_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept && has_out),
		.plan          (plan),
		.free          (free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packet_byte   (packet_byte),
		.packet_end    (packet_end),
		.packet_length (packet_length)
	);

endmodule

// ----- verif/tb_top.sv -----
// Testbench for h264_rtp_fua_packetizer_unit: NAL words in, RTP packet bytes out, with
// directed rows, random NAL streams, register changes, random idling and a long output stall.
// Depends on rfp_pkg and the packetizer RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE = 8;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0]                data;
		logic                      eop;
		logic [rfp_pkg::LEN_W-1:0] len;
	} pkt_byte_t;

	typedef enum {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [rfp_pkg::CFG_IDX_W-1:0]   idx;
		logic [rfp_pkg::CFG_W-1:0]       val;
		logic [7:0]                      nb;
		logic [23:0]                     nl;
		logic [31:0]                     ts;
		logic                            fe;
		int                              n_exp;
		int                              len_exp;
	} stim_row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rfp_pkg::CFG_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic [7:0] nal_byte;
	logic [23:0] nal_length;
	logic [31:0] media_time;
	logic frame_end;
	logic out_valid, out_ready;
	logic [7:0] packet_byte;
	logic packet_end;
	logic [rfp_pkg::LEN_W-1:0] packet_length;

	h264_rtp_fua_packetizer_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.nal_byte(nal_byte), .nal_length(nal_length),
		.media_time(media_time), .frame_end(frame_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.packet_byte(packet_byte), .packet_end(packet_end),
		.packet_length(packet_length)
	);

	// packetizer state mirror
	logic [6:0]                cfg_pt = rfp_pkg::RST_PAYLOAD_TYPE;
	logic [31:0]               cfg_ssrc = rfp_pkg::RST_SYNC_SOURCE;
	logic [12:0]               cfg_max_pl = rfp_pkg::RST_MAX_PAYLOAD;
	logic [15:0]               seq_cnt = rfp_pkg::RST_INIT_SEQ;
	logic [23:0]               nal_left = '0;
	logic [12:0]               pkt_left = '0;
	logic                      first_frag = 1'b0;
	logic [7:0]                nal_hdr = '0;
	logic [rfp_pkg::LEN_W-1:0] pkt_total = '0;

	pkt_byte_t pkt_bytes_due[$];
	int fail_count = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	bit hold_start = 1'b0;

	function automatic int eff_payload();
		if (cfg_max_pl < 3) return 3;
		if (cfg_max_pl > rfp_pkg::MAX_PAYLOAD_LIMIT) return rfp_pkg::MAX_PAYLOAD_LIMIT;
		return int'(cfg_max_pl);
	endfunction

	function automatic void push_byte(logic [7:0] b, logic e);
		pkt_bytes_due.push_back('{data: b, eop: e, len: pkt_total});
	endfunction

	function automatic void push_rtp_header(logic marker, logic [31:0] t);
		push_byte(rfp_pkg::RTP_VERSION_BYTE, 1'b0);
		push_byte({marker, cfg_pt}, 1'b0);
		push_byte(seq_cnt[15:8], 1'b0);
		push_byte(seq_cnt[7:0], 1'b0);
		push_byte(t[31:24], 1'b0);
		push_byte(t[23:16], 1'b0);
		push_byte(t[15:8], 1'b0);
		push_byte(t[7:0], 1'b0);
		push_byte(cfg_ssrc[31:24], 1'b0);
		push_byte(cfg_ssrc[23:16], 1'b0);
		push_byte(cfg_ssrc[15:8], 1'b0);
		push_byte(cfg_ssrc[7:0], 1'b0);
		seq_cnt = seq_cnt + 16'd1;
	endfunction

	// queues the packet bytes one accepted NAL word produces; returns their count
	function automatic int packetize_word(logic [7:0] b, logic [23:0] l, logic [31:0] t,
			logic f);
		int m, cnt, n;
		logic [23:0] ln;
		logic fin;
		logic [7:0] fu;
		m = eff_payload();
		n = 0;
		if (nal_left == 0) begin
			ln = (l == 0) ? 24'd1 : l;
			if (ln <= m) begin
				pkt_total = rfp_pkg::LEN_W'(rfp_pkg::HDR_BYTES + ln);
				push_rtp_header(f, t);
				nal_left = ln - 24'd1;
				pkt_left = 13'(ln - 24'd1);
				push_byte(b, pkt_left == 0);
				return rfp_pkg::HDR_BYTES + 1;
			end
			first_frag = 1'b1;
			nal_hdr = b;
			nal_left = ln - 24'd1;
			pkt_left = '0;
			return 0;
		end
		if (pkt_left == 0) begin
			cnt = m - rfp_pkg::FU_BYTES;
			if (cnt > nal_left) cnt = int'(nal_left);
			fin = (cnt == nal_left);
			fu = (nal_hdr & rfp_pkg::NAL_TYPE_MASK)
				| (first_frag ? rfp_pkg::FU_START_BIT : 8'h00)
				| (fin ? rfp_pkg::FU_END_BIT : 8'h00);
			pkt_total = rfp_pkg::LEN_W'(rfp_pkg::HDR_BYTES + rfp_pkg::FU_BYTES + cnt);
			push_rtp_header(fin & f, t);
			push_byte((nal_hdr & rfp_pkg::NRI_MASK) | rfp_pkg::FU_A_TYPE, 1'b0);
			push_byte(fu, 1'b0);
			first_frag = 1'b0;
			pkt_left = 13'(cnt);
			n = rfp_pkg::HDR_BYTES + rfp_pkg::FU_BYTES;
		end
		pkt_left = pkt_left - 13'd1;
		nal_left = nal_left - 24'd1;
		push_byte(b, pkt_left == 0);
		return n + 1;
	endfunction

	function automatic stim_row_t wr(logic [7:0] b, logic [23:0] l, logic [31:0] t,
			logic f, int n, int len);
		stim_row_t r;
		r = '{kind: ROW_WORD, idx: '0, val: '0, nb: b, nl: l, ts: t, fe: f,
			n_exp: n, len_exp: len};
		return r;
	endfunction

	function automatic stim_row_t rg(logic [rfp_pkg::CFG_IDX_W-1:0] i,
			logic [rfp_pkg::CFG_W-1:0] v);
		stim_row_t r;
		r = '{kind: ROW_REG, idx: i, val: v, nb: '0, nl: '0, ts: '0, fe: 1'b0,
			n_exp: -1, len_exp: -1};
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("** h264_rtp_fua_packetizer_unit: FAILED **");
		$finish;
	end

	initial begin
		int held;
		held = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_start && held < HOLD_CYCLES) begin
				out_ready <= 1'b0;
				held++;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	always @(posedge clk) begin
		pkt_byte_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{data: packet_byte, eop: packet_end, len: packet_length};
			if (pkt_bytes_due.size() == 0) begin
				$display("%0t: unexpected word byte=%02h end=%0b len=%0d", $time,
					got.data, got.eop, got.len);
				fail_count++;
			end else begin
				want = pkt_bytes_due.pop_front();
				if (got !== want) begin
					$display({"%0t: mismatch expected byte=%02h end=%0b len=%0d,",
						" got byte=%02h end=%0b len=%0d"},
						$time, want.data, want.eop, want.len, got.data, got.eop, got.len);
					fail_count++;
				end
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic [23:0] l,
			input logic [31:0] t, input logic f, output int n);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		nal_byte <= b;
		nal_length <= l;
		media_time <= t;
		frame_end <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n = packetize_word(b, l, t, f);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pkt_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(input logic [rfp_pkg::CFG_IDX_W-1:0] i,
			input logic [rfp_pkg::CFG_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= i;
		cfg_data <= v;
		@(posedge clk);
		case (i)
			rfp_pkg::REG_PAYLOAD_TYPE: cfg_pt = v[6:0];
			rfp_pkg::REG_SYNC_SOURCE:  cfg_ssrc = v;
			rfp_pkg::REG_INIT_SEQ:     seq_cnt = v[15:0];
			rfp_pkg::REG_MAX_PAYLOAD:  cfg_max_pl = v[12:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
	endtask

	task automatic random_regs();
		logic [31:0] rnd;
		int r, mp;
		set_reg(rfp_pkg::REG_PAYLOAD_TYPE, $urandom);
		set_reg(rfp_pkg::REG_SYNC_SOURCE, $urandom);
		set_reg(rfp_pkg::REG_INIT_SEQ, $urandom);
		r = $urandom_range(99);
		if (r < 70) mp = $urandom_range(20, 3);
		else if (r < 80) mp = $urandom_range(2, 0);
		else mp = $urandom_range(8191, 21);
		rnd = $urandom;
		set_reg(rfp_pkg::REG_MAX_PAYLOAD, {rnd[31:13], mp[12:0]});
	endtask

	function automatic int pick_nal_len(int m);
		int r;
		r = $urandom_range(99);
		if (r < 5) return 0;
		if (m > 40) return $urandom_range(40, 1);
		if (r < 45) return $urandom_range(m, 1);
		return $urandom_range(3 * m + 2, m + 1);
	endfunction

	task automatic run_random(input int quota);
		int sent, len, ln, n;
		logic [31:0] t, tt;
		logic f, ff;
		logic [23:0] nl;
		sent = 0;
		while (sent < quota) begin
			len = pick_nal_len(eff_payload());
			ln = (len == 0) ? 1 : len;
			t = $urandom;
			f = 1'($urandom_range(1));
			send_word(8'($urandom), 24'(len), t, f, n);
			for (int k = 1; k < ln; k++) begin
				nl = $urandom_range(1) ? 24'($urandom) : 24'(len);
				tt = $urandom_range(3) == 0 ? $urandom : t;
				ff = $urandom_range(7) == 0 ? ~f : f;
				send_word(8'($urandom), nl, tt, ff, n);
			end
			sent += ln;
		end
	endtask

	initial begin
		stim_row_t plan[$];
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		nal_byte = '0;
		nal_length = '0;
		media_time = '0;
		frame_end = 1'b0;
		plan = '{
			wr(8'h65, 24'd1, 32'h0102_0304, 1'b1, 13, 13),
			wr(8'h41, 24'd0, 32'h0000_0000, 1'b0, 13, 13),
			wr(8'h00, 24'd3, 32'hFFFF_FFFF, 1'b1, 13, 15),
			wr(8'hFF, 24'hFF_FFFF, 32'h0000_0000, 1'b0, 1, 15),
			wr(8'hAA, 24'd0, 32'h1234_5678, 1'b1, 1, 15),
			rg(rfp_pkg::REG_PAYLOAD_TYPE, 32'hFFFF_FFFF),
			rg(rfp_pkg::REG_SYNC_SOURCE, 32'hFFFF_FFFF),
			rg(rfp_pkg::REG_INIT_SEQ, 32'h0000_FFFF),
			rg(rfp_pkg::REG_MAX_PAYLOAD, 32'h0000_0000),
			wr(8'h7C, 24'd4, 32'h8000_0000, 1'b1, 0, -1),
			wr(8'h11, 24'd4, 32'h8000_0000, 1'b1, 15, 15),
			wr(8'h22, 24'd4, 32'h8000_0001, 1'b1, 15, 15),
			wr(8'h33, 24'd4, 32'h8000_0002, 1'b1, 15, 15),
			rg(rfp_pkg::REG_PAYLOAD_TYPE, 32'h0),
			rg(rfp_pkg::REG_SYNC_SOURCE, 32'h0),
			rg(rfp_pkg::REG_INIT_SEQ, 32'h0),
			rg(rfp_pkg::REG_MAX_PAYLOAD, 32'd6),
			wr(8'h65, 24'd10, 32'hCAFE_0001, 1'b1, 0, -1),
			wr(8'h01, 24'd10, 32'hCAFE_0002, 1'b1, 15, 18),
			wr(8'h02, 24'd0, 32'hCAFE_0003, 1'b0, 1, 18),
			rg(rfp_pkg::REG_MAX_PAYLOAD, 32'd4),
			wr(8'h03, 24'hFF_FFFF, 32'hCAFE_0004, 1'b1, 1, 18),
			wr(8'h04, 24'd10, 32'hCAFE_0005, 1'b1, 1, 18),
			wr(8'h05, 24'd1, 32'hCAFE_0006, 1'b0, 15, 16),
			wr(8'h06, 24'd10, 32'hCAFE_0007, 1'b1, 1, 16),
			wr(8'h07, 24'd10, 32'hCAFE_0008, 1'b1, 15, 16),
			wr(8'h08, 24'd10, 32'hCAFE_0009, 1'b1, 1, 16),
			wr(8'h09, 24'd10, 32'hCAFE_000A, 1'b1, 15, 15),
			rg(rfp_pkg::REG_MAX_PAYLOAD, 32'hFFFF_FFFF),
			wr(8'h67, 24'd2, 32'h5555_AAAA, 1'b0, 13, 14),
			wr(8'h88, 24'd2, 32'h5555_AAAA, 1'b0, 1, 14),
			rg(rfp_pkg::REG_MAX_PAYLOAD, 32'd3),
			wr(8'h06, 24'd3, 32'hAAAA_5555, 1'b1, 13, 15),
			wr(8'hC3, 24'd3, 32'hAAAA_5555, 1'b1, 1, 15),
			wr(8'h3C, 24'd3, 32'hAAAA_5555, 1'b1, 1, 15)
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 15;
		rx_idle = 57;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				set_reg(plan[i].idx, plan[i].val);
			end else begin
				send_word(plan[i].nb, plan[i].nl, plan[i].ts, plan[i].fe, n);
				if (plan[i].n_exp >= 0 && (n != plan[i].n_exp
						|| (plan[i].len_exp >= 0 && pkt_total != plan[i].len_exp))) begin
					$display("%0t: row %0d expected %0d bytes len %0d, predicted %0d len %0d",
						$time, i, plan[i].n_exp, plan[i].len_exp, n, pkt_total);
					fail_count++;
				end
			end
		end
		random_regs();
		run_random(20);

		tx_idle = 57;
		rx_idle = 15;
		random_regs();
		run_random(20);

		tx_idle = 0;
		rx_idle = 0;
		random_regs();
		hold_start = 1'b1;
		run_random(20);

		// NAL that never ends at the smallest payload: one FU-A packet per word
		set_reg(rfp_pkg::REG_MAX_PAYLOAD, 32'd3);
		send_word(8'h5C, 24'hFF_FFFF, $urandom, 1'b1, n);
		repeat (8) send_word(8'($urandom), 24'($urandom), $urandom,
			1'($urandom_range(1)), n);
		drain();

		if (fail_count == 0) begin
			$display("** h264_rtp_fua_packetizer_unit: PASSED **");
		end else begin
			$display("** h264_rtp_fua_packetizer_unit: FAILED **");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/core/rfp_pkg.sv
rtl/core/rfp_ctrl.sv
rtl/core/rfp_emit.sv
rtl/core/h264_rtp_fua_packetizer_unit.sv
verif/tb_top.sv
